// ===== rtl/slrg_pkg.sv =====
package slrg_pkg;

  localparam int VAL_W        = 31;
  localparam int MUL_W        = 15;
  localparam int PROD_W       = VAL_W + MUL_W;
  localparam int WARMUP_STEPS = 8;

  localparam logic [MUL_W-1:0] LCG_MUL   = 15'd16807;
  localparam logic [VAL_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] OUT_CLAMP = 31'd2147483389;
  localparam logic [VAL_W-1:0] ONE_VAL   = 31'd1;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [PROD_W-1:0] prod_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PFOLD,
    ST_LAUNCH,
    ST_FINISH
  } slrg_state_t;

  // reduce a product modulo 2^31-1 by folding the high part onto the low part
  function automatic val_t mod_fold(input prod_t p);
    logic [VAL_W:0] s;
    logic [VAL_W:0] d;
    s = {1'b0, p[VAL_W-1:0]} + (VAL_W+1)'(p[PROD_W-1:VAL_W]);
    d = s - {1'b0, LCG_MOD};
    if (s >= {1'b0, LCG_MOD}) begin
      return d[VAL_W-1:0];
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

// ===== rtl/shuffled_lehmer_random_generator_unit.sv =====
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_ready   | in_restart
// out     | output    | out_valid / out_ready | out_value
// cfg     | input     | cfg_we (no wait)      | cfg_wdata (seed)
//
// a normal draw does the multiply and table read, then fold and write-back
// priming puts each warm-up step and each table fill step through the modular
// multiply, a PMUL state and then a PFOLD state per step, before the launch
// in_ready is high in idle; a result waiting in the output register does not block it
// a stalled output holds the block in its write-back cycle until out_ready
// rst_n is synchronous; the table needs no clearing, priming fills it first
module shuffled_lehmer_random_generator_unit
  import slrg_pkg::*;
#(
  parameter int TABLE_SIZE = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_value,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata
);

  localparam int IW        = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int LAST_STEP = WARMUP_STEPS + TABLE_SIZE - 1;
  localparam int SW        = $clog2(LAST_STEP + 1);

  slrg_state_t   state_r, state_nxt;
  logic          primed_r, primed_nxt;
  val_t          gen_r, gen_nxt;
  val_t          last_r, last_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  val_t          out_value_r, out_value_nxt;
  val_t          seed_r;

  logic          mul_en;
  val_t          lcg_next;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  val_t          mem_wdata;
  logic          mem_re;
  val_t          mem_rdata;
  logic [IW-1:0] pick_idx;
  logic [SW-1:0] fill_step;
  logic [IW-1:0] fill_addr;
  val_t          seed_fix;
  logic          out_free;

  slrg_lcg u_lcg (
    .clk    (clk),
    .mul_en (mul_en),
    .x      (gen_r),
    .next_x (lcg_next)
  );

  slrg_table #(
    .DEPTH (TABLE_SIZE),
    .AW    (IW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pick_idx),
    .rdata (mem_rdata)
  );

  slrg_index #(
    .TABLE_SIZE (TABLE_SIZE),
    .IW         (IW)
  ) u_index (
    .last (last_r),
    .idx  (pick_idx)
  );

  assign seed_fix  = (seed_r == '0 || seed_r == LCG_MOD) ? ONE_VAL : seed_r;
  assign fill_step = SW'(LAST_STEP) - step_r;
  assign fill_addr = fill_step[IW-1:0];
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    primed_nxt    = primed_r;
    gen_nxt       = gen_r;
    last_nxt      = last_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    mul_en        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = lcg_next;
    mem_re        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!primed_r || in_restart) begin
            gen_nxt   = seed_fix;
            step_nxt  = '0;
            state_nxt = ST_PMUL;
          end else begin
            mul_en    = 1'b1;
            mem_re    = 1'b1;
            idx_nxt   = pick_idx;
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_PMUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_PFOLD;
      end
      ST_PFOLD: begin
        gen_nxt = lcg_next;
        if (step_r >= SW'(WARMUP_STEPS)) begin
          mem_we    = 1'b1;
          mem_waddr = fill_addr;
        end
        if (step_r == SW'(LAST_STEP)) begin
          last_nxt   = lcg_next;
          primed_nxt = 1'b1;
          state_nxt  = ST_LAUNCH;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = ST_PMUL;
        end
      end
      ST_LAUNCH: begin
        mul_en    = 1'b1;
        mem_re    = 1'b1;
        idx_nxt   = pick_idx;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          gen_nxt       = lcg_next;
          mem_we        = 1'b1;
          last_nxt      = mem_rdata;
          out_valid_nxt = 1'b1;
          out_value_nxt = (mem_rdata > OUT_CLAMP) ? OUT_CLAMP : mem_rdata;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      gen_r       <= '0;
      last_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= ONE_VAL;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      gen_r       <= gen_nxt;
      last_r      <= last_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef SYNTH
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside write-back");

  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table read and write in the same cycle");

  a_primed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> (gen_r != '0 && gen_r != LCG_MOD))
    else $error("generator word left its range");

  a_launch_primed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAUNCH || state_r == ST_FINISH) |-> primed_r)
    else $error("draw started without a filled table");
`endif

endmodule

// ===== rtl/slrg_lcg.sv =====
module slrg_lcg
  import slrg_pkg::*;
(
  input  logic clk,
  input  logic mul_en,
  input  val_t x,
  output val_t next_x
);

  prod_t prod_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(x) * PROD_W'(LCG_MUL);
    end
  end

  assign next_x = mod_fold(prod_r);

endmodule

// ===== rtl/slrg_table.sv =====
module slrg_table
  import slrg_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  val_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output val_t          rdata
);

  val_t mem [DEPTH];
  val_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/slrg_index.sv =====
module slrg_index
  import slrg_pkg::*;
#(
  parameter int TABLE_SIZE = 32,
  parameter int IW         = 5
) (
  input  val_t          last,
  output logic [IW-1:0] idx
);

  localparam logic [31:0] PICK_DIV = 32'd1 + (32'd2147483646 / TABLE_SIZE);
  localparam bit          IS_POW2  = (TABLE_SIZE > 1) &&
                                     ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

  generate
    if (IS_POW2) begin : g_shift
      // divisor is a power of two here
      assign idx = last[VAL_W-1 -: IW];
    end else begin : g_ladder
      always_comb begin
        logic [IW-1:0] q;
        q = '0;
        for (int k = 1; k < TABLE_SIZE; k++) begin
          if ({1'b0, last} >= 32'(k) * PICK_DIV) begin
            q = IW'(k);
          end
        end
        idx = q;
      end
    end
  endgenerate

endmodule

// ===== sim/shuffled_lehmer_random_generator_unit_tb.sv =====
`timescale 1ns / 100ps

import slrg_pkg::*;

typedef enum int {
  CHK_OK,
  CHK_WRONG,
  CHK_UNEXPECTED
} draw_check_t;

class lehmer_shuffle_scoreboard;
  localparam int          TBL_SIZE = 32;
  localparam logic [31:0] PICK_DIV = 32'd1 + (32'(LCG_MOD) - 32'd1) / TBL_SIZE;

  val_t seed_reg;
  val_t gen_word;
  val_t last_pick;
  val_t shuffle[TBL_SIZE];
  bit   primed;
  val_t expected_draws[$];

  function new();
    seed_reg  = ONE_VAL;
    gen_word  = '0;
    last_pick = '0;
    primed    = 1'b0;
    foreach (shuffle[i]) shuffle[i] = '0;
  endfunction

  function val_t lehmer_step(val_t x);
    longint unsigned p;
    p = 64'(x) * 64'(LCG_MUL);
    return val_t'(p % 64'(LCG_MOD));
  endfunction

  function void write_seed(val_t v);
    seed_reg = v;
  endfunction

  function void prime_table();
    val_t x;
    x = val_t'(32'(seed_reg) % 32'(LCG_MOD));
    if (x == '0) x = ONE_VAL;
    for (int i = 0; i < WARMUP_STEPS; i++) x = lehmer_step(x);
    for (int i = TBL_SIZE - 1; i >= 0; i--) begin
      x = lehmer_step(x);
      shuffle[i] = x;
    end
    gen_word  = x;
    last_pick = shuffle[0];
    primed    = 1'b1;
  endfunction

  function void note_draw(bit restart);
    logic [31:0] idx;
    val_t        pick;
    if (!primed || restart) prime_table();
    gen_word = lehmer_step(gen_word);
    idx = 32'(last_pick) / PICK_DIV;
    if (idx >= TBL_SIZE) idx = TBL_SIZE - 1;
    pick = shuffle[idx];
    shuffle[idx] = gen_word;
    last_pick = pick;
    expected_draws.push_back((pick > OUT_CLAMP) ? OUT_CLAMP : pick);
  endfunction

  function draw_check_t check_value(val_t got, output val_t want);
    want = '0;
    if (expected_draws.size() == 0) return CHK_UNEXPECTED;
    want = expected_draws.pop_front();
    if (got !== want) return CHK_WRONG;
    return CHK_OK;
  endfunction

  function int pending();
    return expected_draws.size();
  endfunction
endclass

module shuffled_lehmer_random_generator_unit_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_DRAWS    = 115;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic             in_restart = 1'b0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [VAL_W-1:0] out_value;
  logic             cfg_we     = 1'b0;
  logic [VAL_W-1:0] cfg_wdata  = '0;

  lehmer_shuffle_scoreboard sb;

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int stall_left     = 0;
  bit rx_stalls_on   = 1'b0;
  bit tx_gaps_on     = 1'b0;

  shuffled_lehmer_random_generator_unit #(
    .TABLE_SIZE(32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_restart(in_restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string what, val_t got, val_t want);
    mismatch_count++;
    if (mismatch_count <= 200) begin
      $display("%0t: %s, value %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (rx_stalls_on) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : result_monitor
    val_t        want;
    draw_check_t kind;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        kind = sb.check_value(out_value, want);
        if (kind == CHK_UNEXPECTED) begin
          report_mismatch("unexpected transaction", out_value, want);
        end else if (kind == CHK_WRONG) begin
          report_mismatch("wrong out_value", out_value, want);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_draw(bit restart);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    sb.note_draw(restart);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() > 0);
  endtask

  task automatic write_seed(val_t v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    sb.write_seed(v);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic val_t pick_seed();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LCG_MOD - 31'd1;
      3:       return ONE_VAL;
      default: return val_t'($urandom());
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset seed, first draw primes without restart
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);
    wait_drained();

    // new seed is ignored until a restart
    write_seed('0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);
    wait_drained();

    // all-ones seed folds to zero and is taken as one
    write_seed('1);
    send_draw(1'b1);
    send_draw(1'b0);
    wait_drained();

    write_seed(LCG_MOD - 31'd1);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);
    wait_drained();

    write_seed(ONE_VAL);
    send_draw(1'b1);
    send_draw(1'b1);
    send_draw(1'b0);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      rx_stalls_on = (p == 0) ? 1'b0 : bit'($urandom_range(0, 3) != 0);
      tx_gaps_on   = (p == 0) ? 1'b0 : bit'($urandom_range(0, 3) != 0);
      write_seed(pick_seed());
      send_draw(bit'($urandom_range(0, 1)));
      for (int k = 1; k < PHASE_DRAWS; k++) begin
        if (p == 3 && k == 57) wait_drained();
        send_draw(bit'($urandom_range(0, 15) == 0));
      end
      wait_drained();
    end

    rx_stalls_on = 1'b0;
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
